FILE: src/quaternion_arithmetic_unit_defines.svh
// assertion macros for the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH
`define QUATERNION_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication
`define QAU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/qau_pkg.sv
package qau_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	localparam int PROD_BITS  = 2 * WORD_BITS;
	localparam int SUM_BITS   = PROD_BITS + 2;
	localparam int SHR_BITS   = SUM_BITS - FRAC_BITS;
	localparam int M2_BITS    = PROD_BITS + 1;
	localparam int ROOT_BITS  = WORD_BITS + 1;
	localparam int TRIAL_BITS = M2_BITS + 2;
	localparam int Q_BITS     = FRAC_BITS + 1;
	localparam int NUM_BITS   = WORD_BITS + FRAC_BITS + 1;
	localparam int DIV_BITS   = ROOT_BITS + Q_BITS;

	// squares, sum, root steps, divider setup, quotient steps, sign
	localparam int NORM_LAT = 3 + ROOT_BITS + Q_BITS + 1;
	localparam int HAM_LAT  = 4;

	localparam int IN_DATA_BITS  = ((8 * WORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((4 * WORD_BITS + 7) / 8) * 8;

	typedef logic signed [WORD_BITS-1:0] word_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [SUM_BITS-1:0]  sum_t;

	typedef struct packed {
		logic  sat;
		word_t val;
	} sat_word_t;

	typedef enum logic [1:0] {
		FUNC_MUL  = 2'd0,
		FUNC_ROT  = 2'd1,
		FUNC_CONJ = 2'd2,
		FUNC_NORM = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_SAT  = 2'd1,
		STATUS_ZERO = 2'd2
	} status_t;

	localparam word_t WORD_MAX   = {1'b0, {(WORD_BITS - 1){1'b1}}};
	localparam word_t WORD_MIN   = {1'b1, {(WORD_BITS - 1){1'b0}}};
	localparam sum_t  ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);

	// hamilton product: row r, term k uses a[k] * q[HAM_Q[r][k]]
	localparam int HAM_Q [4][4] = '{
		'{0, 1, 2, 3},
		'{1, 0, 3, 2},
		'{2, 3, 0, 1},
		'{3, 2, 1, 0}
	};
	localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b0010, 4'b0100};

	function automatic sat_word_t round_sat(input sum_t acc);
		sum_t                        rnd;
		logic [SHR_BITS-1:0]         sh;
		logic [SHR_BITS-WORD_BITS:0] top;
		sat_word_t                   res;
		rnd = acc + ROUND_HALF;
		sh  = rnd[SUM_BITS-1:FRAC_BITS];
		top = sh[SHR_BITS-1:WORD_BITS-1];
		if ((&top) || !(|top)) begin
			res.sat = 1'b0;
			res.val = $signed(sh[WORD_BITS-1:0]);
		end else begin
			res.sat = 1'b1;
			res.val = top[SHR_BITS-WORD_BITS] ? WORD_MIN : WORD_MAX;
		end
		return res;
	endfunction

	// conj_q negates the vector part of the right operand
	function automatic sat_word_t ham_row(input prod_t prod [16], input int row,
			input logic conj_q);
		sum_t       acc;
		logic [3:0] idx;
		logic       neg;
		acc = '0;
		for (int k = 0; k < 4; k++) begin
			idx = 4'(k * 4 + HAM_Q[row][k]);
			neg = HAM_NEG[row][k] ^ (conj_q && (HAM_Q[row][k] != 0));
			acc = neg ? acc - sum_t'(prod[idx]) : acc + sum_t'(prod[idx]);
		end
		return round_sat(acc);
	endfunction

endpackage

FILE: src/qau_norm.sv
module qau_norm (
	input  logic              clk,
	input  logic              en,
	input  qau_pkg::word_t    a [4],
	output qau_pkg::word_t    r [4],
	output logic              zero
);

	logic [qau_pkg::WORD_BITS-1:0] mag_in [4];
	logic [qau_pkg::WORD_BITS-1:0] mag_s1 [4];
	logic                          neg_s1 [4];
	logic [qau_pkg::PROD_BITS-1:0] sq_s1 [4];

	logic [qau_pkg::M2_BITS-1:0]   sqr_rem_s  [qau_pkg::ROOT_BITS+1];
	logic [qau_pkg::ROOT_BITS-1:0] sqr_root_s [qau_pkg::ROOT_BITS+1];
	logic [qau_pkg::WORD_BITS-1:0] sqr_mag_s  [qau_pkg::ROOT_BITS+1][4];
	logic                          sqr_neg_s  [qau_pkg::ROOT_BITS+1][4];

	logic [qau_pkg::TRIAL_BITS-1:0] trial [qau_pkg::ROOT_BITS];
	logic                           sqr_take [qau_pkg::ROOT_BITS];

	logic [qau_pkg::NUM_BITS-1:0]  div_rem_s  [qau_pkg::Q_BITS+1][4];
	logic [qau_pkg::Q_BITS-1:0]    div_q_s    [qau_pkg::Q_BITS+1][4];
	logic [qau_pkg::ROOT_BITS:0]   div_d_s    [qau_pkg::Q_BITS+1];
	logic                          div_zero_s [qau_pkg::Q_BITS+1];
	logic                          div_neg_s  [qau_pkg::Q_BITS+1][4];

	logic [qau_pkg::DIV_BITS-1:0]  dsh [qau_pkg::Q_BITS];
	logic                          div_take [qau_pkg::Q_BITS][4];

	qau_pkg::word_t r_q [4];
	logic           zero_q;
	qau_pkg::word_t qw [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_in[i] = a[i][qau_pkg::WORD_BITS-1] ?
				qau_pkg::WORD_BITS'(-a[i]) : qau_pkg::WORD_BITS'(a[i]);
		end
	end

	// one root bit per stage, msb first
	always_comb begin
		for (int j = 0; j < qau_pkg::ROOT_BITS; j++) begin
			trial[j] = (qau_pkg::TRIAL_BITS'(sqr_root_s[j]) << (qau_pkg::ROOT_BITS - j))
				| (qau_pkg::TRIAL_BITS'(1) << (2 * (qau_pkg::ROOT_BITS - 1 - j)));
			sqr_take[j] = qau_pkg::TRIAL_BITS'(sqr_rem_s[j]) >= trial[j];
		end
	end

	// one quotient bit per stage, msb first
	always_comb begin
		for (int k = 0; k < qau_pkg::Q_BITS; k++) begin
			dsh[k] = qau_pkg::DIV_BITS'(div_d_s[k]) << (qau_pkg::Q_BITS - 1 - k);
			for (int i = 0; i < 4; i++) begin
				div_take[k][i] = qau_pkg::DIV_BITS'(div_rem_s[k][i]) >= dsh[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qw[i] = $signed(qau_pkg::WORD_BITS'(div_q_s[qau_pkg::Q_BITS][i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mag_s1[i] <= mag_in[i];
				neg_s1[i] <= a[i][qau_pkg::WORD_BITS-1];
				sq_s1[i]  <= qau_pkg::PROD_BITS'(mag_in[i]) * qau_pkg::PROD_BITS'(mag_in[i]);
			end

			sqr_rem_s[0]  <= qau_pkg::M2_BITS'(sq_s1[0]) + qau_pkg::M2_BITS'(sq_s1[1])
				+ qau_pkg::M2_BITS'(sq_s1[2]) + qau_pkg::M2_BITS'(sq_s1[3]);
			sqr_root_s[0] <= '0;
			sqr_mag_s[0]  <= mag_s1;
			sqr_neg_s[0]  <= neg_s1;

			for (int j = 0; j < qau_pkg::ROOT_BITS; j++) begin
				sqr_rem_s[j+1]  <= sqr_take[j] ?
					qau_pkg::M2_BITS'(qau_pkg::TRIAL_BITS'(sqr_rem_s[j]) - trial[j])
					: sqr_rem_s[j];
				sqr_root_s[j+1] <= sqr_take[j] ?
					(sqr_root_s[j] | (qau_pkg::ROOT_BITS'(1) << (qau_pkg::ROOT_BITS - 1 - j)))
					: sqr_root_s[j];
				sqr_mag_s[j+1]  <= sqr_mag_s[j];
				sqr_neg_s[j+1]  <= sqr_neg_s[j];
			end

			// divide by twice the root for round half away from zero
			div_d_s[0]    <= {sqr_root_s[qau_pkg::ROOT_BITS], 1'b0};
			div_zero_s[0] <= sqr_root_s[qau_pkg::ROOT_BITS] == '0;
			div_neg_s[0]  <= sqr_neg_s[qau_pkg::ROOT_BITS];
			for (int i = 0; i < 4; i++) begin
				div_rem_s[0][i] <= (qau_pkg::NUM_BITS'(sqr_mag_s[qau_pkg::ROOT_BITS][i])
					<< qau_pkg::Q_BITS)
					+ qau_pkg::NUM_BITS'(sqr_root_s[qau_pkg::ROOT_BITS]);
				div_q_s[0][i]   <= '0;
			end

			for (int k = 0; k < qau_pkg::Q_BITS; k++) begin
				div_d_s[k+1]    <= div_d_s[k];
				div_zero_s[k+1] <= div_zero_s[k];
				div_neg_s[k+1]  <= div_neg_s[k];
				for (int i = 0; i < 4; i++) begin
					div_rem_s[k+1][i] <= div_take[k][i] ?
						qau_pkg::NUM_BITS'(qau_pkg::DIV_BITS'(div_rem_s[k][i]) - dsh[k])
						: div_rem_s[k][i];
					div_q_s[k+1][i]   <= div_take[k][i] ?
						(div_q_s[k][i] | (qau_pkg::Q_BITS'(1) << (qau_pkg::Q_BITS - 1 - k)))
						: div_q_s[k][i];
				end
			end

			zero_q <= div_zero_s[qau_pkg::Q_BITS];
			for (int i = 0; i < 4; i++) begin
				if (div_zero_s[qau_pkg::Q_BITS]) begin
					r_q[i] <= '0;
				end else begin
					r_q[i] <= div_neg_s[qau_pkg::Q_BITS][i] ? -qw[i] : qw[i];
				end
			end
		end
	end

	assign r    = r_q;
	assign zero = zero_q;

endmodule

FILE: src/quaternion_arithmetic_unit.sv
// Quaternion arithmetic on signed Q15.16 words: Hamilton product, vector
// rotation by A*(0,v)*conj(A), conjugate and normalize, chosen per beat by
// s_axis_tuser. The unit takes one beat per clock while s_axis_tready is high
// and returns one result beat per input beat, in order. The normalize path is
// the longest: one square-root bit per stage (33 stages) followed by one
// quotient bit per stage (17 stages) for the division by the root; the other
// operations are delayed to match. A result refused by the sink moves into a
// one-beat skid register, and while that register is full the pipeline holds
// and s_axis_tready is low. Saturated results report status 1; a zero
// magnitude under normalize gives zeros with status 2.
`include "quaternion_arithmetic_unit_defines.svh"

module quaternion_arithmetic_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z
	input  logic [qau_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
	// func
	input  logic [1:0]                           s_axis_tuser,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// r_w, r_x, r_y, r_z
	output logic [qau_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,
	// status
	output logic [1:0]                           m_axis_tuser
);

	logic en;

	qau_pkg::func_t func_in;
	qau_pkg::word_t a_in [4];
	qau_pkg::word_t b_in [4];
	qau_pkg::word_t qv_in [4];
	qau_pkg::word_t conj_in [4];
	logic           csat_in;

	logic           pipe_valid_s [1:qau_pkg::NORM_LAT];
	qau_pkg::func_t pipe_func_s  [1:qau_pkg::NORM_LAT];

	qau_pkg::prod_t prod1_s1 [16];
	qau_pkg::word_t a_s1 [4];
	qau_pkg::word_t conj_s1 [4];
	logic           csat_s1;

	qau_pkg::word_t a_s2 [4];
	qau_pkg::word_t t_s2 [4];
	logic           tsat_s2;

	qau_pkg::prod_t prod2_s3 [16];
	qau_pkg::word_t t_s3 [4];
	logic           tsat_s3;

	qau_pkg::word_t ham_s  [qau_pkg::HAM_LAT:qau_pkg::NORM_LAT][4];
	logic           hsat_s [qau_pkg::HAM_LAT:qau_pkg::NORM_LAT];

	qau_pkg::sat_word_t h1 [4];
	qau_pkg::sat_word_t h2 [4];
	qau_pkg::word_t     t_nx [4];
	logic               tsat_nx;
	qau_pkg::word_t     res_nx [4];
	logic               rsat_nx;

	qau_pkg::word_t  norm_r [4];
	logic            norm_zero;

	qau_pkg::word_t   out_nx [4];
	qau_pkg::status_t status_nx;

	logic             out_v_q;
	qau_pkg::word_t   out_r_q [4];
	qau_pkg::status_t out_status_q;
	logic             skid_v_q;
	qau_pkg::word_t   skid_r_q [4];
	qau_pkg::status_t skid_status_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;
	assign func_in       = qau_pkg::func_t'(s_axis_tuser);

	always_comb begin
		csat_in = 1'b0;
		for (int i = 0; i < 4; i++) begin
			a_in[i]  = $signed(s_axis_tdata[i * qau_pkg::WORD_BITS +: qau_pkg::WORD_BITS]);
			b_in[i]  = $signed(s_axis_tdata[(4 + i) * qau_pkg::WORD_BITS +: qau_pkg::WORD_BITS]);
			qv_in[i] = (func_in == qau_pkg::FUNC_ROT && i == 0) ? '0 : b_in[i];
			if (i == 0) begin
				conj_in[i] = a_in[i];
			end else if (a_in[i] == qau_pkg::WORD_MIN) begin
				conj_in[i] = qau_pkg::WORD_MAX;
				csat_in    = 1'b1;
			end else begin
				conj_in[i] = -a_in[i];
			end
		end
	end

	qau_norm u_norm (
		.clk  (clk),
		.en   (en),
		.a    (a_in),
		.r    (norm_r),
		.zero (norm_zero)
	);

	// first product, or conjugate
	always_comb begin
		tsat_nx = pipe_func_s[1] == qau_pkg::FUNC_CONJ ? csat_s1 : 1'b0;
		for (int r = 0; r < 4; r++) begin
			h1[r] = qau_pkg::ham_row(prod1_s1, r, 1'b0);
			if (pipe_func_s[1] == qau_pkg::FUNC_CONJ) begin
				t_nx[r] = conj_s1[r];
			end else begin
				t_nx[r] = h1[r].val;
				tsat_nx = tsat_nx | h1[r].sat;
			end
		end
	end

	// second product for rotate, by conj(a)
	always_comb begin
		rsat_nx = tsat_s3;
		for (int r = 0; r < 4; r++) begin
			h2[r] = qau_pkg::ham_row(prod2_s3, r, 1'b1);
			if (pipe_func_s[3] == qau_pkg::FUNC_ROT) begin
				res_nx[r] = (r == 0) ? '0 : h2[r].val;
				rsat_nx   = rsat_nx | h2[r].sat;
			end else begin
				res_nx[r] = t_s3[r];
			end
		end
	end

	always_comb begin
		if (pipe_func_s[qau_pkg::NORM_LAT] == qau_pkg::FUNC_NORM) begin
			out_nx    = norm_r;
			status_nx = norm_zero ? qau_pkg::STATUS_ZERO : qau_pkg::STATUS_OK;
		end else begin
			out_nx    = ham_s[qau_pkg::NORM_LAT];
			status_nx = hsat_s[qau_pkg::NORM_LAT] ? qau_pkg::STATUS_SAT : qau_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= qau_pkg::NORM_LAT; k++) begin
				pipe_valid_s[k] <= 1'b0;
			end
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			pipe_valid_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= qau_pkg::NORM_LAT; k++) begin
				pipe_valid_s[k] <= pipe_valid_s[k-1];
			end
			out_v_q <= pipe_valid_s[qau_pkg::NORM_LAT];
			if (out_v_q && !m_axis_tready) begin
				skid_v_q <= 1'b1;
			end
		end else if (m_axis_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_func_s[1] <= func_in;
			for (int k = 2; k <= qau_pkg::NORM_LAT; k++) begin
				pipe_func_s[k] <= pipe_func_s[k-1];
			end

			for (int p = 0; p < 4; p++) begin
				for (int q = 0; q < 4; q++) begin
					prod1_s1[p * 4 + q] <= qau_pkg::prod_t'(a_in[p]) * qau_pkg::prod_t'(qv_in[q]);
					prod2_s3[p * 4 + q] <= qau_pkg::prod_t'(t_s2[p]) * qau_pkg::prod_t'(a_s2[q]);
				end
			end
			a_s1    <= a_in;
			conj_s1 <= conj_in;
			csat_s1 <= csat_in;

			a_s2    <= a_s1;
			t_s2    <= t_nx;
			tsat_s2 <= tsat_nx;

			t_s3    <= t_s2;
			tsat_s3 <= tsat_s2;

			ham_s[qau_pkg::HAM_LAT]  <= res_nx;
			hsat_s[qau_pkg::HAM_LAT] <= rsat_nx;
			for (int k = qau_pkg::HAM_LAT + 1; k <= qau_pkg::NORM_LAT; k++) begin
				ham_s[k]  <= ham_s[k-1];
				hsat_s[k] <= hsat_s[k-1];
			end

			out_r_q      <= out_nx;
			out_status_q <= status_nx;
			skid_r_q      <= out_r_q;
			skid_status_q <= out_status_q;
		end
	end

	assign m_axis_tvalid = skid_v_q || out_v_q;
	assign m_axis_tuser  = skid_v_q ? skid_status_q : out_status_q;

	always_comb begin
		m_axis_tdata = '0;
		for (int i = 0; i < 4; i++) begin
			m_axis_tdata[i * qau_pkg::WORD_BITS +: qau_pkg::WORD_BITS] =
				skid_v_q ? skid_r_q[i] : out_r_q[i];
		end
	end

	`QAU_ASSERT_NEXT(a_enter_stage1, s_axis_tvalid && s_axis_tready, pipe_valid_s[1], "accepted beat did not enter the pipeline")
	`QAU_ASSERT_IMPL(a_skid_load, $rose(skid_v_q), $past(out_v_q && !m_axis_tready), "skid loaded without a refused beat")
	`QAU_ASSERT_NEXT(a_zero_status, en && pipe_valid_s[qau_pkg::NORM_LAT] && pipe_func_s[qau_pkg::NORM_LAT] == qau_pkg::FUNC_NORM && norm_zero, out_status_q == qau_pkg::STATUS_ZERO, "zero magnitude not flagged")

endmodule
